/* hw/rtl/matrix_add_multiply_engine_macros.svh */
// Assertion macros for the matrix add/multiply engine.
// Used by the top level; the macros expect clk and arst_n in scope.
`ifndef MATRIX_ADD_MULTIPLY_ENGINE_MACROS_SVH
`define MATRIX_ADD_MULTIPLY_ENGINE_MACROS_SVH

`ifndef SYNTH
`define MAME_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define MAME_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MAME_ASSERT_IMPLY(lbl, ante, cons, msg)
`define MAME_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/mame_pkg.sv */
// Shared types and constants of the matrix add/multiply engine.
// No dependencies; imported by the engine top level and by the testbench.
`timescale 1ns / 1ps

package mame_pkg;

	localparam int VALUE_W  = 16;
	localparam int RESULT_W = 40;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 4'd3;

	typedef enum logic [1:0] {
		MODE_LOAD_A  = 2'd0,
		MODE_LOAD_B  = 2'd1,
		MODE_SUM     = 2'd2,
		MODE_PRODUCT = 2'd3
	} mame_mode_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_ADD_ERR = 2'd1,
		STATUS_MUL_ERR = 2'd2
	} mame_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} mame_state_t;

	typedef struct packed {
		mame_mode_t                 mode;
		logic [2:0]                 row;
		logic [2:0]                 col;
		logic signed [VALUE_W-1:0]  value;
	} mame_in_t;

	typedef struct packed {
		logic [2:0]                 row_res;
		logic [2:0]                 col_res;
		logic signed [RESULT_W-1:0] result;
		mame_status_t               status;
		logic                       last;
	} mame_out_t;

endpackage

/* hw/rtl/mame_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mame_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/matrix_add_multiply_engine.sv */
// Matrix add/multiply engine: two element RAMs, one shared multiply/add unit, a sequencer.
// A load request is taken in the idle state; an error request goes straight to the emit step.
// Each product element issues one read per column of A, then drains the pipeline and emits;
// a sum element issues a single read. The input is held off until a request is finished.
// One request is worked on at a time; the emit step waits while the output register is held.
// Reset clears control and sets all dimension registers to 1; element stores are not cleared.
`timescale 1ns / 1ps
`include "matrix_add_multiply_engine_macros.svh"

module matrix_add_multiply_engine
	import mame_pkg::*;
#(
	parameter int MAX_DIM = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  mame_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mame_out_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam logic [DIM_W-1:0]  MAXD     = DIM_W'(MAX_DIM);
	localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(MAX_DIM);

	function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DATA_W-1:0] v);
		logic [4:0] v5;
		v5 = 5'(v);
		if (v == '0) begin
			return DIM_W'(1);
		end else if (v5 > 5'(MAX_DIM)) begin
			return MAXD;
		end else begin
			return DIM_W'(v);
		end
	endfunction

	mame_state_t state_q, state_d;

	logic [CFG_DATA_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
	logic [DIM_W-1:0]      ra, ca, rb, cb, jlen, klen;

	logic                  prod_q, err_q;
	mame_status_t          err_status_q;
	logic [IDX_W-1:0]      i_q, j_q, k_q;
	logic                  v_s1, first_s1, v_s2, first_s2;
	logic signed [31:0]    prod_s2, unit_res;
	logic signed [RESULT_W-1:0] acc_q;
	logic                  out_valid_q;
	mame_out_t             out_q, out_d;

	logic                  in_acc, load_row_ok, we_a, we_b;
	logic [ADDR_W-1:0]     waddr, a_raddr, b_raddr;
	logic [VALUE_W-1:0]    a_rdata, b_rdata;
	logic                  add_bad, mul_bad, start, issue, out_free, out_load;
	logic                  k_last, i_last, j_last, elem_last;

	assign ra = eff_dim(rows_a_q);
	assign ca = eff_dim(cols_a_q);
	assign rb = eff_dim(rows_b_q);
	assign cb = eff_dim(cols_b_q);
	assign jlen = prod_q ? cb : ca;
	assign klen = prod_q ? ca : DIM_W'(1);

	assign add_bad = (ra != rb) || (ca != cb);
	assign mul_bad = (ca != rb);

	assign k_last = (DIM_W'(k_q) + DIM_W'(1)) == klen;
	assign i_last = (DIM_W'(i_q) + DIM_W'(1)) == ra;
	assign j_last = (DIM_W'(j_q) + DIM_W'(1)) == jlen;
	assign elem_last = i_last && j_last;

	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	assign load_row_ok = (5'(in_data.row) < 5'(MAX_DIM)) && (5'(in_data.col) < 5'(MAX_DIM));
	assign we_a  = in_acc && (in_data.mode == MODE_LOAD_A) && load_row_ok;
	assign we_b  = in_acc && (in_data.mode == MODE_LOAD_B) && load_row_ok;
	assign waddr = ADDR_W'(in_data.row) * ROW_STEP + ADDR_W'(in_data.col);
	assign start = in_acc && ((in_data.mode == MODE_SUM) || (in_data.mode == MODE_PRODUCT));

	assign a_raddr = ADDR_W'(i_q) * ROW_STEP + ADDR_W'(prod_q ? k_q : j_q);
	assign b_raddr = ADDR_W'(prod_q ? k_q : i_q) * ROW_STEP + ADDR_W'(j_q);

	mame_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (in_data.value),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	mame_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (in_data.value),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (in_data.mode)
						MODE_LOAD_A, MODE_LOAD_B: state_d = ST_IDLE;
						MODE_SUM:     state_d = add_bad ? ST_EMIT : ST_ISSUE;
						MODE_PRODUCT: state_d = mul_bad ? ST_EMIT : ST_ISSUE;
					endcase
				end
			end
			ST_ISSUE: begin
				if (k_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = (err_q || elem_last) ? ST_IDLE : ST_ISSUE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_ISSUE: issue    = 1'b1;
			ST_DRAIN: ;
			ST_EMIT:  out_load = out_free;
			default: ;
		endcase
	end

	always_comb begin
		if (prod_q) begin
			unit_res = 32'($signed(a_rdata)) * 32'($signed(b_rdata));
		end else begin
			unit_res = 32'($signed(a_rdata)) + 32'($signed(b_rdata));
		end
	end

	always_comb begin
		out_d = '0;
		if (err_q) begin
			out_d.status = err_status_q;
			out_d.last   = 1'b1;
		end else begin
			out_d.row_res = 3'(i_q);
			out_d.col_res = 3'(j_q);
			out_d.result  = acc_q;
			out_d.status  = STATUS_OK;
			out_d.last    = elem_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rows_a_q    <= CFG_DATA_W'(1);
			cols_a_q    <= CFG_DATA_W'(1);
			rows_b_q    <= CFG_DATA_W'(1);
			cols_b_q    <= CFG_DATA_W'(1);
			prod_q      <= 1'b0;
			err_q       <= 1'b0;
			err_status_q <= STATUS_OK;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ROWS_A) begin
					rows_a_q <= cfg_data;
				end
				if (cfg_index == REG_COLS_A) begin
					cols_a_q <= cfg_data;
				end
				if (cfg_index == REG_ROWS_B) begin
					rows_b_q <= cfg_data;
				end
				if (cfg_index == REG_COLS_B) begin
					cols_b_q <= cfg_data;
				end
			end
			if (start) begin
				prod_q       <= (in_data.mode == MODE_PRODUCT);
				err_q        <= (in_data.mode == MODE_PRODUCT) ? mul_bad : add_bad;
				err_status_q <= (in_data.mode == MODE_PRODUCT) ? STATUS_MUL_ERR
				                                               : STATUS_ADD_ERR;
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end
			if (issue) begin
				k_q <= k_last ? '0 : k_q + IDX_W'(1);
			end
			if (out_load && !err_q) begin
				if (j_last) begin
					j_q <= '0;
					i_q <= i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (k_q == '0);
		first_s2 <= first_s1;
		prod_s2  <= unit_res;
		if (v_s2) begin
			acc_q <= (first_s2 ? RESULT_W'(0) : acc_q) + RESULT_W'(prod_s2);
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`MAME_ASSERT_IMPLY(a_emit_drained, state_q == ST_EMIT, !v_s1 && !v_s2, "emit with busy pipeline")
	`MAME_ASSERT_IMPLY(a_k_in_range, state_q == ST_ISSUE, (DIM_W'(k_q) < klen), "k index past limit")
	`MAME_ASSERT_IMPLY(a_err_shape, out_valid_q && out_q.status != STATUS_OK, out_q.last && out_q.result == '0, "bad error result")
	`MAME_ASSERT_NEXT(a_err_done, state_q == ST_EMIT && out_free && err_q, state_q == ST_IDLE, "error run did not end")

endmodule

/* dv/tb_top.sv */
// Self-checking bench for matrix_add_multiply_engine: loads, sums and products under random
// handshake gaps, checked element by element against a matrix model kept in this file.
// Depends on mame_pkg and the engine RTL only.
`timescale 1ns / 1ps

module tb_top;
	import mame_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int MAX_DIM = 8;
	localparam int SETTLE_CYCLES = 16;
	localparam int STIM_ITEMS = 250;

	typedef struct packed {
		logic                  is_cfg;
		mame_in_t              req;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} stim_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	mame_in_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	mame_out_t             out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic in_hs = 1'b0;
	logic cfg_hs = 1'b0;
	logic out_hs = 1'b0;
	logic in_calm = 1'b0;
	logic out_calm = 1'b0;
	int unsigned send_gap = 0;
	int unsigned out_wait = 0;
	int unsigned idle_cnt = 0;
	int unsigned err_cnt = 0;

	stim_t pending_requests[$];
	mame_out_t expected_elems[$];

	logic signed [VALUE_W-1:0] mat_a [MAX_DIM*MAX_DIM];
	logic signed [VALUE_W-1:0] mat_b [MAX_DIM*MAX_DIM];
	logic [CFG_DATA_W-1:0] dim_reg [4] = '{4'd1, 4'd1, 4'd1, 4'd1};

	int unsigned gen_dim [4] = '{1, 1, 1, 1};
	bit a_set [MAX_DIM*MAX_DIM];
	bit b_set [MAX_DIM*MAX_DIM];
	int unsigned gen_cnt = 0;

	matrix_add_multiply_engine #(.MAX_DIM(MAX_DIM)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2.0) clk = ~clk;

	function automatic int unsigned dim_in_use(input logic [CFG_DATA_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	function automatic mame_out_t make_elem(input int unsigned r, input int unsigned c,
			input longint acc, input mame_status_t st, input logic lst);
		mame_out_t e;
		e.row_res = 3'(r);
		e.col_res = 3'(c);
		e.result = acc[RESULT_W-1:0];
		e.status = st;
		e.last = lst;
		return e;
	endfunction

	task automatic compute_expected_elements(input mame_in_t req);
		int unsigned ra, ca, rb, cb;
		longint acc;
		ra = dim_in_use(dim_reg[REG_ROWS_A]);
		ca = dim_in_use(dim_reg[REG_COLS_A]);
		rb = dim_in_use(dim_reg[REG_ROWS_B]);
		cb = dim_in_use(dim_reg[REG_COLS_B]);
		case (req.mode)
			MODE_LOAD_A: mat_a[req.row * MAX_DIM + req.col] = req.value;
			MODE_LOAD_B: mat_b[req.row * MAX_DIM + req.col] = req.value;
			MODE_SUM: begin
				if (ra != rb || ca != cb) begin
					expected_elems.push_back(make_elem(0, 0, 0, STATUS_ADD_ERR, 1'b1));
				end else begin
					for (int i = 0; i < ra; i++)
						for (int j = 0; j < ca; j++) begin
							acc = longint'(mat_a[i*MAX_DIM+j]) + longint'(mat_b[i*MAX_DIM+j]);
							expected_elems.push_back(make_elem(i, j, acc, STATUS_OK,
								(i == ra - 1) && (j == ca - 1)));
						end
				end
			end
			default: begin
				if (ca != rb) begin
					expected_elems.push_back(make_elem(0, 0, 0, STATUS_MUL_ERR, 1'b1));
				end else begin
					for (int i = 0; i < ra; i++)
						for (int j = 0; j < cb; j++) begin
							acc = 0;
							for (int k = 0; k < ca; k++)
								acc += longint'(mat_a[i*MAX_DIM+k]) * longint'(mat_b[k*MAX_DIM+j]);
							expected_elems.push_back(make_elem(i, j, acc, STATUS_OK,
								(i == ra - 1) && (j == cb - 1)));
						end
				end
			end
		endcase
	endtask

	always @(posedge clk) begin : monitor
		mame_out_t e;
		in_hs <= in_valid && in_ready;
		cfg_hs <= cfg_valid && cfg_ready;
		out_hs <= out_valid && out_ready;
		if (out_valid && out_ready) begin
			if (expected_elems.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected result: row %0d col %0d result %0d status %0d last %0b",
						out_data.row_res, out_data.col_res, out_data.result, out_data.status,
						out_data.last);
			end else begin
				e = expected_elems.pop_front();
				if (out_data.row_res !== e.row_res || out_data.col_res !== e.col_res ||
						out_data.result !== e.result || out_data.status !== e.status ||
						out_data.last !== e.last) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("mismatch: exp row %0d col %0d result %0d status %0d last %0b, got row %0d col %0d result %0d status %0d last %0b",
							e.row_res, e.col_res, e.result, e.status, e.last,
							out_data.row_res, out_data.col_res, out_data.result,
							out_data.status, out_data.last);
				end
			end
		end
		if (cfg_valid && cfg_ready && cfg_index <= REG_COLS_B)
			dim_reg[cfg_index] = cfg_data;
		if (in_valid && in_ready)
			compute_expected_elements(in_data);
		if (expected_elems.size() == 0 && !in_valid && !cfg_valid) begin
			if (idle_cnt < SETTLE_CYCLES)
				idle_cnt <= idle_cnt + 1;
		end else begin
			idle_cnt <= 0;
		end
	end

	always @(negedge clk) begin : driver
		stim_t nxt;
		int unsigned g;
		g = in_calm ? 0 : $urandom_range(0, 19);
		if (!arst_n || (in_valid && !in_hs) || (cfg_valid && !cfg_hs)) begin
		end else if (send_gap != 0) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_requests.size() != 0 && !pending_requests[0].is_cfg) begin
			nxt = pending_requests.pop_front();
			in_valid <= 1'b1;
			in_data <= nxt.req;
			cfg_valid <= 1'b0;
			send_gap <= g;
			if ($urandom_range(0, 15) == 0)
				in_calm <= ~in_calm;
		end else if (pending_requests.size() != 0 && idle_cnt >= SETTLE_CYCLES) begin
			nxt = pending_requests.pop_front();
			cfg_valid <= 1'b1;
			cfg_index <= nxt.idx;
			cfg_data <= nxt.data;
			in_valid <= 1'b0;
			send_gap <= g;
		end else begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
		end
	end

	always @(negedge clk) begin : sink
		int unsigned g;
		g = out_calm ? 0 : $urandom_range(0, 19);
		if (out_hs) begin
			out_wait <= g;
			out_ready <= (g == 0);
			if ($urandom_range(0, 15) == 0)
				out_calm <= ~out_calm;
		end else if (out_wait != 0) begin
			out_wait <= out_wait - 1;
			out_ready <= (out_wait == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_dim();
		case ($urandom_range(0, 9))
			0: return 4'd0;
			1: return 4'($urandom_range(9, 15));
			2, 3: return 4'($urandom_range(5, 8));
			default: return 4'($urandom_range(1, 4));
		endcase
	endfunction

	task automatic push_req(input mame_mode_t m, input int unsigned r, input int unsigned c,
			input logic [VALUE_W-1:0] v);
		stim_t s;
		s = '0;
		s.req.mode = m;
		s.req.row = 3'(r);
		s.req.col = 3'(c);
		s.req.value = v;
		pending_requests.push_back(s);
		gen_cnt++;
		if (m == MODE_LOAD_A)
			a_set[r*MAX_DIM+c] = 1'b1;
		else if (m == MODE_LOAD_B)
			b_set[r*MAX_DIM+c] = 1'b1;
	endtask

	task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		stim_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.idx = idx;
		s.data = d;
		pending_requests.push_back(s);
		if (idx <= REG_COLS_B)
			gen_dim[idx] = dim_in_use(d);
	endtask

	// Every element that the compute will read is written first.
	task automatic push_compute(input mame_mode_t m);
		int unsigned ra, ca, rb, cb, a_rows, a_cols, b_rows, b_cols;
		bit ok;
		ra = gen_dim[REG_ROWS_A];
		ca = gen_dim[REG_COLS_A];
		rb = gen_dim[REG_ROWS_B];
		cb = gen_dim[REG_COLS_B];
		a_rows = ra;
		a_cols = ca;
		b_rows = (m == MODE_SUM) ? ra : rb;
		b_cols = (m == MODE_SUM) ? ca : cb;
		ok = (m == MODE_SUM) ? (ra == rb && ca == cb) : (ca == rb);
		if (ok) begin
			for (int i = 0; i < a_rows; i++)
				for (int j = 0; j < a_cols; j++)
					if (!a_set[i*MAX_DIM+j])
						push_req(MODE_LOAD_A, i, j, pick_value());
			for (int i = 0; i < b_rows; i++)
				for (int j = 0; j < b_cols; j++)
					if (!b_set[i*MAX_DIM+j])
						push_req(MODE_LOAD_B, i, j, pick_value());
		end
		push_req(m, $urandom_range(0, 7), $urandom_range(0, 7), 16'($urandom));
	endtask

	initial begin : stimulus
		mame_mode_t m;
		int unsigned lim_r, lim_c;
		push_req(MODE_LOAD_A, 0, 0, 16'h7FFF);
		push_req(MODE_LOAD_B, 0, 0, 16'h7FFF);
		push_compute(MODE_SUM);
		push_compute(MODE_PRODUCT);
		push_req(MODE_LOAD_A, 0, 0, 16'h8000);
		push_req(MODE_LOAD_B, 0, 0, 16'h8000);
		push_compute(MODE_SUM);
		push_compute(MODE_PRODUCT);
		push_req(MODE_LOAD_B, 0, 0, 16'h7FFF);
		push_compute(MODE_PRODUCT);
		push_cfg(REG_COLS_A, 4'd2);
		push_compute(MODE_SUM);
		push_compute(MODE_PRODUCT);
		push_cfg(REG_COLS_A, 4'd0);
		push_cfg(REG_ROWS_A, 4'd15);
		push_compute(MODE_SUM);
		push_compute(MODE_PRODUCT);
		push_cfg(4'd15, 4'd10);
		push_cfg(4'd4, 4'd5);
		push_cfg(REG_ROWS_B, 4'd0);
		push_cfg(REG_COLS_B, 4'd9);
		push_compute(MODE_PRODUCT);

		push_cfg(REG_ROWS_A, 4'd8);
		push_cfg(REG_COLS_A, 4'd12);
		push_cfg(REG_ROWS_B, 4'd15);
		push_cfg(REG_COLS_B, 4'd8);
		push_compute(MODE_PRODUCT);
		push_compute(MODE_SUM);

		while (gen_cnt < STIM_ITEMS) begin
			if ($urandom_range(0, 7) == 0)
				push_cfg(4'($urandom_range(4, 15)), 4'($urandom));
			for (int i = 0; i < 4; i++)
				if ($urandom_range(0, 1))
					push_cfg(4'(i), pick_dim());
			case ($urandom_range(0, 2))
				0: begin
					push_cfg(REG_ROWS_B, 4'(gen_dim[REG_ROWS_A]));
					push_cfg(REG_COLS_B, 4'(gen_dim[REG_COLS_A]));
				end
				1: push_cfg(REG_ROWS_B, 4'(gen_dim[REG_COLS_A]));
				default: ;
			endcase
			repeat ($urandom_range(1, 3)) begin
				repeat ($urandom_range(0, 6)) begin
					m = $urandom_range(0, 1) ? MODE_LOAD_B : MODE_LOAD_A;
					lim_r = (m == MODE_LOAD_A) ? gen_dim[REG_ROWS_A] : gen_dim[REG_ROWS_B];
					lim_c = (m == MODE_LOAD_A) ? gen_dim[REG_COLS_A] : gen_dim[REG_COLS_B];
					if ($urandom_range(0, 3) != 0)
						push_req(m, $urandom_range(0, lim_r - 1), $urandom_range(0, lim_c - 1),
							pick_value());
					else
						push_req(m, $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
				end
				push_compute($urandom_range(0, 1) ? MODE_PRODUCT : MODE_SUM);
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || in_valid || cfg_valid ||
				expected_elems.size() != 0)
			@(negedge clk);
		repeat (4 * SETTLE_CYCLES) @(negedge clk);
		if (err_cnt == 0 && expected_elems.size() == 0)
			$display("[matrix_add_multiply_engine] OK");
		else
			$display("[matrix_add_multiply_engine] ERROR");
		$finish;
	end

	initial begin : watchdog
		#(CLK_PERIOD * 3000000);
		$display("[matrix_add_multiply_engine] ERROR");
		$finish;
	end

endmodule
